// ===== hdl/vrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared constants and types for the voxel ray traversal block.
// ----------------------------------------------------------------------------
package vrt_pkg;

	localparam int WORLD_SIDE_DEF  = 64;
	localparam int CHUNK_WIDTH_DEF = 16;
	localparam int CHUNK_TALL_DEF  = 16;

	localparam int ORG_W   = 27;
	localparam int DIR_W   = 16;
	localparam int REACH_W = 24;
	localparam int TIME_W  = 41;
	localparam int CELL_W  = 13;
	localparam int QUO_W   = 31;

	localparam logic [TIME_W-1:0] T_INF = TIME_W'(64'd1 << 40);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic signed [CELL_W-1:0] cell_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} store_cmd_t;

endpackage

// ===== hdl/vrt_recip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_recip
// Bit-serial restoring divider computing floor(2^30 / divisor).
// ----------------------------------------------------------------------------
module vrt_recip (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [vrt_pkg::DIR_W-1:0] divisor,
	output logic                      done,
	output logic [vrt_pkg::QUO_W-1:0] quotient
);
	import vrt_pkg::*;

	logic [DIR_W:0]   rem_q;
	logic [DIR_W-1:0] div_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [QUO_W-1:0] quo_q;
	logic [DIR_W+1:0] trial;
	logic [DIR_W+1:0] diff;

	// dividend is a single one at bit 30
	assign trial = {rem_q, (cnt_q == 5'd30)};
	assign diff  = trial - (DIR_W+2)'(div_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd30;
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			if (trial >= (DIR_W+2)'(div_q)) begin
				rem_q <= diff[DIR_W:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIR_W:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/vrt_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_store
// Occupancy memory, one row per (x, y) holding all z bits, with a
// clearing pass after reset.
// ----------------------------------------------------------------------------
module vrt_store #(
	parameter int WORLD_SIDE = vrt_pkg::WORLD_SIDE_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  vrt_pkg::store_cmd_t                    cmd,
	input  logic [$clog2(WORLD_SIDE*WORLD_SIDE)-1:0] row,
	input  logic [WORLD_SIDE-1:0]                  wr_data,
	output logic [WORLD_SIDE-1:0]                  rd_data,
	output logic                                   ready
);
	import vrt_pkg::*;

	localparam int ROWS = WORLD_SIDE * WORLD_SIDE;
	localparam int RW   = $clog2(ROWS);

	logic [WORLD_SIDE-1:0] mem [ROWS];
	logic [RW-1:0]         clr_q;
	logic                  clearing_q;
	logic [WORLD_SIDE-1:0] rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (clr_q == RW'(ROWS - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_q <= clr_q + RW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_q] <= '0;
		end else if (cmd.wr) begin
			mem[row] <= wr_data;
		end
		if (cmd.rd) begin
			rd_q <= mem[row];
		end
	end

	assign rd_data = rd_q;
	assign ready   = !clearing_q;

endmodule

// ===== hdl/voxel_ray_traversal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_traversal
// Voxel grid ray caster over a one-bit occupancy memory.
//
// Requests arrive on req_valid/req_ready, one result per request leaves on
// rsp_valid/rsp_ready. op selects a cell write or a ray cast. One request
// is worked on at a time; a finished result waits in the output register
// while the next request is taken.
// A write passes through the row read, row write back (skipped for a cell
// out of range) and finish states before its result shows.
// A cast first sets up each axis in turn (a 31-step reciprocal division
// on one shared divider, a multiply and the axis load), then tests one
// cell at a time (memory read, then test and step).
// A miss ends with the final time check, a hit then splits the hit cell
// into chunk and offset, and both end in the finish state.
// The next request can be taken in the cycle after the result is posted.
// After reset the memory is swept clear, one row per cycle, over all
// WORLD_SIDE*WORLD_SIDE rows (4096 by default); req_ready stays low then.
// When the receiver stalls, the result is held and a second finished
// result waits inside until the output register frees up.
// ----------------------------------------------------------------------------
module voxel_ray_traversal #(
	parameter int WORLD_SIDE  = vrt_pkg::WORLD_SIDE_DEF,
	parameter int CHUNK_WIDTH = vrt_pkg::CHUNK_WIDTH_DEF,
	parameter int CHUNK_TALL  = vrt_pkg::CHUNK_TALL_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic               op,
	input  logic [5:0]         cell_x,
	input  logic [5:0]         cell_y,
	input  logic [5:0]         cell_z,
	input  logic               blocks_ray,
	input  logic signed [26:0] origin_x,
	input  logic signed [26:0] origin_y,
	input  logic signed [26:0] origin_z,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	input  logic [23:0]        reach,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic               hit,
	output logic [23:0]        distance,
	output logic signed [1:0]  normal_x,
	output logic signed [1:0]  normal_y,
	output logic signed [1:0]  normal_z,
	output logic signed [6:0]  chunk_x,
	output logic signed [6:0]  chunk_y,
	output logic signed [6:0]  chunk_z,
	output logic [3:0]         local_x,
	output logic [3:0]         local_y,
	output logic [3:0]         local_z
);
	import vrt_pkg::*;

	localparam int CIW   = $clog2(WORLD_SIDE);
	localparam int RW    = $clog2(WORLD_SIDE * WORLD_SIDE);
	localparam int KSH   = 20;
	localparam int REC_W = (2**KSH + CHUNK_WIDTH - 1) / CHUNK_WIDTH;
	localparam int REC_T = (2**KSH + CHUNK_TALL - 1) / CHUNK_TALL;

	typedef enum logic [3:0] {
		S_IDLE, S_WR_RD, S_WR_WB, S_DIV_GO, S_DIV_WAIT, S_MUL, S_AX_SET,
		S_RD, S_CHK, S_CH1, S_CH2, S_FIN
	} state_t;

	state_t state_q;

	logic [1:0]             ax_q;
	logic [5:0]             wx_q, wy_q, wz_q;
	logic                   wbit_q;
	logic [ORG_W-1:0]       org_q [3];
	logic [DIR_W-1:0]       dir_q [3];
	logic [REACH_W-1:0]     reach_q;
	cell_t                  cell_q [3];
	logic                   neg_q [3];
	time_t                  tdelta_q [3];
	time_t                  tmax_q [3];
	time_t                  t_q;
	logic [47:0]            prod_q;
	logic                   inb_q;
	logic [CIW-1:0]         quo_q [3];

	logic                   res_hit_q;
	logic [23:0]            res_dist_q;
	logic [1:0]             res_nrm_q [3];
	logic [6:0]             res_chunk_q [3];
	logic [3:0]             res_local_q [3];

	store_cmd_t             st_cmd;
	logic [RW-1:0]          st_row;
	logic [WORLD_SIDE-1:0]  st_wdata;
	logic [WORLD_SIDE-1:0]  st_rdata;
	logic                   st_ready;

	logic                   div_start;
	logic [DIR_W-1:0]       div_abs;
	logic                   div_done;
	logic [QUO_W-1:0]       div_quo;
	logic [16:0]            f_val;

	logic                   inb;
	logic [CIW-1:0]         ci [3];
	logic                   lt_xy, lt_xz, lt_yz;
	logic                   wr_in_range;
	logic                   out_free;

	vrt_recip u_recip (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (div_abs),
		.done     (div_done),
		.quotient (div_quo)
	);

	vrt_store #(
		.WORLD_SIDE (WORLD_SIDE)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (st_cmd),
		.row     (st_row),
		.wr_data (st_wdata),
		.rd_data (st_rdata),
		.ready   (st_ready)
	);

	function automatic time_t sat_add(time_t a, time_t b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, T_INF}) ? T_INF : s[TIME_W-1:0];
	endfunction

	assign req_ready   = (state_q == S_IDLE) && st_ready;
	assign out_free    = !rsp_valid || rsp_ready;
	assign wr_in_range = (32'(wx_q) < WORLD_SIDE) && (32'(wy_q) < WORLD_SIDE)
		&& (32'(wz_q) < WORLD_SIDE);

	assign div_abs = dir_q[ax_q][DIR_W-1] ? DIR_W'(-dir_q[ax_q]) : dir_q[ax_q];
	assign f_val   = dir_q[ax_q][DIR_W-1] ? {1'b0, org_q[ax_q][15:0]}
		: (17'h10000 - {1'b0, org_q[ax_q][15:0]});
	assign div_start = (state_q == S_DIV_GO);

	always_comb begin
		inb = 1'b1;
		for (int a = 0; a < 3; a++) begin
			ci[a] = cell_q[a][CIW-1:0];
			if (cell_q[a] < 0 || cell_q[a] >= CELL_W'(WORLD_SIDE)) begin
				inb = 1'b0;
			end
		end
	end

	assign lt_xy = tmax_q[0] < tmax_q[1];
	assign lt_xz = tmax_q[0] < tmax_q[2];
	assign lt_yz = tmax_q[1] < tmax_q[2];

	always_comb begin
		st_cmd   = '0;
		st_row   = RW'(RW'(ci[0]) * RW'(WORLD_SIDE) + RW'(ci[1]));
		st_wdata = st_rdata;
		case (state_q)
			S_WR_RD: begin
				st_cmd.rd = 1'b1;
				st_row    = RW'(RW'(wx_q) * RW'(WORLD_SIDE) + RW'(wy_q));
			end
			S_WR_WB: begin
				st_cmd.wr = 1'b1;
				st_row    = RW'(RW'(wx_q) * RW'(WORLD_SIDE) + RW'(wy_q));
				st_wdata[CIW'(wz_q)] = wbit_q;
			end
			S_RD: begin
				st_cmd.rd = (t_q <= TIME_W'(reach_q)) && inb;
			end
			default: begin
				st_cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ax_q      <= '0;
			rsp_valid <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				rsp_valid <= 1'b1;
			end else if (rsp_valid && rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid && req_ready) begin
						ax_q <= '0;
						if (op == OP_CAST) begin
							state_q <= S_DIV_GO;
						end else begin
							state_q <= S_WR_RD;
						end
					end
				end
				S_WR_RD: begin
					state_q <= wr_in_range ? S_WR_WB : S_FIN;
				end
				S_WR_WB: state_q <= S_FIN;
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (div_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_AX_SET;
				S_AX_SET: begin
					if (ax_q == 2'd2) begin
						state_q <= S_RD;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_DIV_GO;
					end
				end
				S_RD: begin
					state_q <= (t_q <= TIME_W'(reach_q)) ? S_CHK : S_FIN;
				end
				S_CHK: begin
					state_q <= (inb_q && st_rdata[ci[2]]) ? S_CH1 : S_RD;
				end
				S_CH1: state_q <= S_CH2;
				S_CH2: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				wx_q     <= cell_x;
				wy_q     <= cell_y;
				wz_q     <= cell_z;
				wbit_q   <= blocks_ray;
				org_q[0] <= origin_x;
				org_q[1] <= origin_y;
				org_q[2] <= origin_z;
				dir_q[0] <= dir_x;
				dir_q[1] <= dir_y;
				dir_q[2] <= dir_z;
				reach_q  <= reach;
				res_hit_q  <= 1'b0;
				res_dist_q <= '0;
				for (int a = 0; a < 3; a++) begin
					res_nrm_q[a]   <= '0;
					res_chunk_q[a] <= '0;
					res_local_q[a] <= '0;
				end
			end
			S_MUL: begin
				prod_q <= 48'(f_val) * 48'(div_quo);
			end
			S_AX_SET: begin
				cell_q[ax_q] <= CELL_W'(signed'(org_q[ax_q][ORG_W-1:16]));
				neg_q[ax_q]  <= dir_q[ax_q][DIR_W-1] || (dir_q[ax_q] == '0);
				if (dir_q[ax_q] == '0) begin
					tdelta_q[ax_q] <= T_INF;
					tmax_q[ax_q]   <= T_INF;
				end else begin
					tdelta_q[ax_q] <= TIME_W'(div_quo);
					tmax_q[ax_q]   <= TIME_W'(prod_q[47:16]);
				end
				t_q <= '0;
			end
			S_RD: begin
				inb_q <= inb;
			end
			S_CHK: begin
				if (inb_q && st_rdata[ci[2]]) begin
					res_hit_q  <= 1'b1;
					res_dist_q <= t_q[23:0];
				end else if (lt_xy && lt_xz) begin
					cell_q[0]    <= neg_q[0] ? cell_q[0] - CELL_W'(1) : cell_q[0] + CELL_W'(1);
					t_q          <= tmax_q[0];
					tmax_q[0]    <= sat_add(tmax_q[0], tdelta_q[0]);
					res_nrm_q[0] <= neg_q[0] ? 2'sd1 : -2'sd1;
					res_nrm_q[1] <= '0;
					res_nrm_q[2] <= '0;
				end else if (lt_xy || !lt_yz) begin
					cell_q[2]    <= neg_q[2] ? cell_q[2] - CELL_W'(1) : cell_q[2] + CELL_W'(1);
					t_q          <= tmax_q[2];
					tmax_q[2]    <= sat_add(tmax_q[2], tdelta_q[2]);
					res_nrm_q[0] <= '0;
					res_nrm_q[1] <= '0;
					res_nrm_q[2] <= neg_q[2] ? 2'sd1 : -2'sd1;
				end else begin
					cell_q[1]    <= neg_q[1] ? cell_q[1] - CELL_W'(1) : cell_q[1] + CELL_W'(1);
					t_q          <= tmax_q[1];
					tmax_q[1]    <= sat_add(tmax_q[1], tdelta_q[1]);
					res_nrm_q[0] <= '0;
					res_nrm_q[1] <= neg_q[1] ? 2'sd1 : -2'sd1;
					res_nrm_q[2] <= '0;
				end
			end
			S_CH1: begin
				quo_q[0] <= CIW'((32'(ci[0]) * 32'(REC_W)) >> KSH);
				quo_q[1] <= CIW'((32'(ci[1]) * 32'(REC_T)) >> KSH);
				quo_q[2] <= CIW'((32'(ci[2]) * 32'(REC_W)) >> KSH);
			end
			S_CH2: begin
				res_chunk_q[0] <= 7'(quo_q[0]);
				res_chunk_q[1] <= 7'(quo_q[1]);
				res_chunk_q[2] <= 7'(quo_q[2]);
				res_local_q[0] <= 4'(ci[0] - CIW'(32'(quo_q[0]) * CHUNK_WIDTH));
				res_local_q[1] <= 4'(ci[1] - CIW'(32'(quo_q[1]) * CHUNK_TALL));
				res_local_q[2] <= 4'(ci[2] - CIW'(32'(quo_q[2]) * CHUNK_WIDTH));
			end
			S_FIN: begin
				if (!res_hit_q) begin
					res_dist_q <= '0;
					for (int a = 0; a < 3; a++) begin
						res_nrm_q[a] <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// output register, loaded when the result leaves the finish state
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			hit      <= res_hit_q;
			distance <= res_hit_q ? res_dist_q : '0;
			normal_x <= res_hit_q ? res_nrm_q[0] : '0;
			normal_y <= res_hit_q ? res_nrm_q[1] : '0;
			normal_z <= res_hit_q ? res_nrm_q[2] : '0;
			chunk_x  <= res_chunk_q[0];
			chunk_y  <= res_chunk_q[1];
			chunk_z  <= res_chunk_q[2];
			local_x  <= res_local_q[0];
			local_y  <= res_local_q[1];
			local_z  <= res_local_q[2];
		end
	end

endmodule

// ===== verif/tb_voxel_ray_traversal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_ray_traversal
// Self-checking testbench for the voxel grid ray caster.
//
// A queue of requests (cell writes and ray casts) feeds a clocked driver.
// Each accepted request goes through a local model of the occupancy store
// and the grid walk. The expected result is queued, and a clocked monitor
// checks every result against it field by field. Both handshakes idle at
// random, with one quiet stretch. The sender drains all results before
// three marked requests. A watchdog ends a run that stops making progress.
// ----------------------------------------------------------------------------
module tb_voxel_ray_traversal;
	import vrt_pkg::*;

	localparam int          SIDE      = WORLD_SIDE_DEF;
	localparam longint      TINF      = longint'(1) << 40;
	localparam int          WDOG_MAX  = 40000;
	localparam longint      ONE       = 65536;

	typedef struct {
		logic               op;
		logic [5:0]         cx, cy, cz;
		logic               blk;
		logic signed [26:0] ox, oy, oz;
		logic signed [15:0] dx, dy, dz;
		logic [23:0]        reach;
		bit                 drain_first;
	} voxel_req_t;

	typedef struct {
		logic               hit;
		logic [23:0]        distance;
		logic signed [1:0]  nx, ny, nz;
		logic signed [6:0]  chx, chy, chz;
		logic [3:0]         lx, ly, lz;
	} ray_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic op = 1'b0;
	logic [5:0] cell_x = '0, cell_y = '0, cell_z = '0;
	logic blocks_ray = 1'b0;
	logic signed [26:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic signed [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic [23:0] reach = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic hit;
	logic [23:0] distance;
	logic signed [1:0] normal_x, normal_y, normal_z;
	logic signed [6:0] chunk_x, chunk_y, chunk_z;
	logic [3:0] local_x, local_y, local_z;

	voxel_req_t pending_reqs[$];
	ray_rsp_t   expected_hits[$];
	bit         solid_cells[SIDE*SIDE*SIDE];
	int         errors = 0;
	int         accepted_reqs = 0;
	int         casts_done = 0;
	int         hits_seen = 0;
	int         idle_cycles = 0;

	voxel_ray_traversal i_dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit quiet_stretch();
		return accepted_reqs >= 500 && accepted_reqs < 700;
	endfunction

	function automatic bit store_solid(longint x, longint y, longint z);
		if (x < 0 || y < 0 || z < 0 || x >= SIDE || y >= SIDE || z >= SIDE)
			return 1'b0;
		return solid_cells[(x * SIDE + y) * SIDE + z];
	endfunction

	task automatic axis_init(input longint org, input longint d, output longint cidx,
			output longint stp, output longint tdel, output longint tnext);
		longint frac, ad, f;
		cidx = org >>> 16;
		frac = org - cidx * ONE;
		stp = d > 0 ? 1 : -1;
		if (d == 0) begin
			tdel = TINF;
			tnext = TINF;
		end else begin
			ad = d < 0 ? -d : d;
			tdel = (longint'(1) << 30) / ad;
			f = d > 0 ? ONE - frac : frac;
			tnext = (f * tdel) >>> 16;
		end
	endtask

	function automatic longint add_sat(longint a, longint b);
		return (a + b > TINF) ? TINF : a + b;
	endfunction

	task automatic trace_ray(input voxel_req_t r, output ray_rsp_t res);
		longint x, y, z, sx, sy, sz, dlx, dly, dlz, mx, my, mz, t, lim;
		longint nx, ny, nz;
		res = '{default: '0};
		nx = 0; ny = 0; nz = 0;
		axis_init(longint'(r.ox), longint'(r.dx), x, sx, dlx, mx);
		axis_init(longint'(r.oy), longint'(r.dy), y, sy, dly, my);
		axis_init(longint'(r.oz), longint'(r.dz), z, sz, dlz, mz);
		lim = longint'(r.reach);
		t = 0;
		while (t <= lim) begin
			if (store_solid(x, y, z)) begin
				res.hit = 1'b1;
				res.distance = t[23:0];
				res.nx = nx[1:0];
				res.ny = ny[1:0];
				res.nz = nz[1:0];
				res.chx = 7'(x / CHUNK_WIDTH_DEF);
				res.chy = 7'(y / CHUNK_TALL_DEF);
				res.chz = 7'(z / CHUNK_WIDTH_DEF);
				res.lx = 4'(x % CHUNK_WIDTH_DEF);
				res.ly = 4'(y % CHUNK_TALL_DEF);
				res.lz = 4'(z % CHUNK_WIDTH_DEF);
				return;
			end
			if (mx < my && mx < mz) begin
				x += sx; t = mx; mx = add_sat(mx, dlx);
				nx = -sx; ny = 0; nz = 0;
			end else if (mx < my || !(my < mz)) begin
				z += sz; t = mz; mz = add_sat(mz, dlz);
				nx = 0; ny = 0; nz = -sz;
			end else begin
				y += sy; t = my; my = add_sat(my, dly);
				nx = 0; ny = -sy; nz = 0;
			end
		end
	endtask

	task automatic predict_request(input voxel_req_t r);
		ray_rsp_t res;
		res = '{default: '0};
		if (r.op == OP_WRITE)
			solid_cells[(int'(r.cx) * SIDE + int'(r.cy)) * SIDE + int'(r.cz)] = r.blk;
		else begin
			trace_ray(r, res);
			casts_done++;
			if (res.hit)
				hits_seen++;
		end
		expected_hits = {expected_hits, res};
	endtask

	task automatic report_mismatch(input string field, input longint got, input longint exp);
		errors++;
		if (errors <= 40)
			$display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, exp);
	endtask

	function automatic voxel_req_t mk_write(int x, int y, int z, bit b);
		voxel_req_t r;
		r = '{default: '0};
		r.op = OP_WRITE;
		r.cx = 6'(x); r.cy = 6'(y); r.cz = 6'(z);
		r.blk = b;
		r.ox = 27'($urandom); r.dx = 16'($urandom); r.reach = 24'($urandom);
		return r;
	endfunction

	function automatic voxel_req_t mk_cast(longint ox, longint oy, longint oz,
			int dx, int dy, int dz, int rch);
		voxel_req_t r;
		r = '{default: '0};
		r.op = OP_CAST;
		r.cx = 6'($urandom); r.cy = 6'($urandom); r.cz = 6'($urandom);
		r.blk = 1'($urandom);
		r.ox = 27'(ox); r.oy = 27'(oy); r.oz = 27'(oz);
		r.dx = 16'(dx); r.dy = 16'(dy); r.dz = 16'(dz);
		r.reach = 24'(rch);
		return r;
	endfunction

	function automatic int dense_coord();
		if ($urandom_range(99) < 80)
			return $urandom_range(39, 24);
		return $urandom_range(63, 0);
	endfunction

	function automatic longint inner_origin();
		if ($urandom_range(99) < 50)
			return longint'($urandom_range(40 * 65536 - 1, 20 * 65536));
		return longint'($urandom_range(SIDE * 65536 - 1, 0));
	endfunction

	function automatic voxel_req_t rand_req();
		voxel_req_t r;
		int sel;
		sel = $urandom_range(99);
		if (sel < 40)
			r = mk_write(dense_coord(), dense_coord(), dense_coord(), $urandom_range(99) < 75);
		else if (sel < 88)
			r = mk_cast(inner_origin(), inner_origin(), inner_origin(),
				$signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
				$urandom_range(24 * 65536, 0));
		else if (sel < 94)
			r = mk_cast($signed(27'($urandom)), $signed(27'($urandom)), $signed(27'($urandom)),
				$signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
				$urandom_range(99) < 30 ? int'(24'($urandom)) : $urandom_range(4 * 65536, 0));
		else
			r = mk_cast(inner_origin(), inner_origin(), inner_origin(),
				$urandom_range(1) ? 0 : $signed(16'($urandom)),
				$urandom_range(1) ? 0 : $signed(16'($urandom)),
				$urandom_range(1) ? 0 : $signed(16'($urandom)),
				int'(24'($urandom)));
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		voxel_req_t cur;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				cur = pending_reqs[0];
				pending_reqs.delete(0);
				predict_request(cur);
				accepted_reqs++;
			end
			if (!req_valid || req_ready) begin
				if (pending_reqs.size() == 0 ||
						(pending_reqs[0].drain_first && expected_hits.size() != 0) ||
						(!quiet_stretch() && $urandom_range(99) < 26)) begin
					req_valid <= 1'b0;
				end else begin
					req_valid <= 1'b1;
					op <= pending_reqs[0].op;
					cell_x <= pending_reqs[0].cx;
					cell_y <= pending_reqs[0].cy;
					cell_z <= pending_reqs[0].cz;
					blocks_ray <= pending_reqs[0].blk;
					origin_x <= pending_reqs[0].ox;
					origin_y <= pending_reqs[0].oy;
					origin_z <= pending_reqs[0].oz;
					dir_x <= pending_reqs[0].dx;
					dir_y <= pending_reqs[0].dy;
					dir_z <= pending_reqs[0].dz;
					reach <= pending_reqs[0].reach;
					pending_reqs[0].drain_first = 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		ray_rsp_t e;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_hits.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					e = expected_hits[0];
					expected_hits.delete(0);
					if (hit !== e.hit) report_mismatch("hit", hit, e.hit);
					if (distance !== e.distance) report_mismatch("distance", distance, e.distance);
					if (normal_x !== e.nx) report_mismatch("normal_x", normal_x, e.nx);
					if (normal_y !== e.ny) report_mismatch("normal_y", normal_y, e.ny);
					if (normal_z !== e.nz) report_mismatch("normal_z", normal_z, e.nz);
					if (chunk_x !== e.chx) report_mismatch("chunk_x", chunk_x, e.chx);
					if (chunk_y !== e.chy) report_mismatch("chunk_y", chunk_y, e.chy);
					if (chunk_z !== e.chz) report_mismatch("chunk_z", chunk_z, e.chz);
					if (local_x !== e.lx) report_mismatch("local_x", local_x, e.lx);
					if (local_y !== e.ly) report_mismatch("local_y", local_y, e.ly);
					if (local_z !== e.lz) report_mismatch("local_z", local_z, e.lz);
				end
			end
			rsp_ready <= quiet_stretch() || $urandom_range(99) >= 26;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("watchdog expired after %0d cycles without progress", idle_cycles);
			$display("voxel_ray_traversal regression: fail");
			$finish;
		end
	end

	initial begin
		voxel_req_t r;
		// directed: hits, normals, extremes, zero direction, outside cells
		pending_reqs = {pending_reqs, mk_write(5, 5, 5, 1)};
		pending_reqs = {pending_reqs, mk_write(63, 63, 63, 1)};
		pending_reqs = {pending_reqs, mk_write(0, 0, 0, 1)};
		pending_reqs = {pending_reqs, mk_cast(2 * ONE + ONE / 2, 5 * ONE + 100,
			5 * ONE + 9000, 16384, 0, 0, 16 * 65536)};
		pending_reqs = {pending_reqs, mk_cast(8 * ONE, 5 * ONE + 1, 5 * ONE + 1,
			-32768, 0, 0, 16 * 65536)};
		pending_reqs = {pending_reqs, mk_cast(5 * ONE + 7, 1 * ONE, 5 * ONE + 7,
			0, 32767, 0, 16777215)};
		pending_reqs = {pending_reqs, mk_cast(5 * ONE + 7, 5 * ONE + 7, 9 * ONE,
			0, 0, -32768, 16777215)};
		pending_reqs = {pending_reqs, mk_cast(5 * ONE + 3, 5 * ONE + 3, 5 * ONE + 3,
			0, 0, 0, 0)};
		pending_reqs = {pending_reqs, mk_cast(7 * ONE, 7 * ONE, 7 * ONE, 0, 0, 0, 16777215)};
		pending_reqs = {pending_reqs, mk_cast(ONE / 2, ONE / 2, ONE / 2,
			16384, 16384, 16384, 0)};
		pending_reqs = {pending_reqs, mk_cast(-3 * ONE, ONE / 2, ONE / 2,
			16384, 0, 0, 16 * 65536)};
		pending_reqs = {pending_reqs, mk_cast(67 * ONE, 63 * ONE + 5, 63 * ONE + 5,
			-16384, 0, 0, 16 * 65536)};
		pending_reqs = {pending_reqs, mk_cast(3 * ONE, 3 * ONE, 3 * ONE,
			-16384, -16384, -16384, 16 * 65536)};
		pending_reqs = {pending_reqs, mk_cast(67108863, 67108863, 67108863,
			32767, 32767, 32767, 16777215)};
		pending_reqs = {pending_reqs, mk_cast(-67108864, -67108864, -67108864,
			-32768, -32768, -32768, 16777215)};
		pending_reqs = {pending_reqs, mk_cast(2 * ONE, 2 * ONE, 2 * ONE, 1, -1, 1, 16777215)};
		pending_reqs = {pending_reqs, mk_write(5, 5, 5, 0)};
		pending_reqs = {pending_reqs, mk_cast(2 * ONE + ONE / 2, 5 * ONE + 100,
			5 * ONE + 9000, 16384, 0, 0, 4 * 65536)};
		r = mk_write(0, 0, 0, 0);
		r.drain_first = 1'b1;
		pending_reqs = {pending_reqs, r};
		for (int i = 0; i < 1300; i++) begin
			r = rand_req();
			if (i == 300 || i == 900)
				r.drain_first = 1'b1;
			pending_reqs = {pending_reqs, r};
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_reqs.size() == 0 && expected_hits.size() == 0 && !req_valid);
		repeat (300) @(posedge clk);
		if (expected_hits.size() != 0)
			report_mismatch("results left over", expected_hits.size(), 0);
		$display("requests accepted: %0d, ray casts: %0d of which %0d hit",
			accepted_reqs, casts_done, hits_seen);
		if (errors == 0)
			$display("voxel_ray_traversal regression: pass");
		else
			$display("voxel_ray_traversal regression: fail");
		$finish;
	end

endmodule
